/* sv/dosv_pkg.sv */
// shared constants, microcode format, microcode table and helpers for the voice block
package dosv_pkg;

  // bank size
  localparam int NUM_OSC    = 8;
  localparam int OVERSAMPLE = 8;

  // oscillator datapath widths
  localparam int PHASE_W = 32;
  localparam int PSUM_W  = PHASE_W + $clog2(NUM_OSC);
  localparam int SUM_W   = PHASE_W + $clog2(NUM_OSC * OVERSAMPLE);
  localparam int Y_W     = SUM_W - 9;
  localparam int OSC_W   = 24 + $clog2(OVERSAMPLE);
  localparam int REP_W   = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;

  // floor divide by NUM_OSC as a round-up reciprocal multiply, exact for y < 2^Y_W
  localparam int RECIP_K = Y_W + $clog2(NUM_OSC);
  localparam int M_W     = Y_W + 1;
  localparam int OSCM_W  = Y_W + M_W;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << RECIP_K) + 64'(NUM_OSC) - 64'd1) / 64'(NUM_OSC);
  localparam logic [M_W-1:0] RECIP_M = RECIP_FULL[M_W-1:0];

  // filter datapath widths
  localparam int DATA_W  = 32;
  localparam int CUT_W   = 16;
  localparam int DAMP_W  = 17;
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int FRAC_W  = 16;
  localparam int SH_W    = PROD_W - FRAC_W;
  localparam int DIFF_W  = 34;
  localparam int EXT_W   = 38;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_INCREMENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DETUNE_STEP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_MASK_TOP  = 2'd2;
  localparam int MASK_W = 8;

  // microcode steps
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_TICK    = 4'd1;
  localparam logic [STEP_W-1:0] STEP_DRAIN   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_OSC     = 4'd3;
  localparam logic [STEP_W-1:0] STEP_DIFF1   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_MULCD1  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_BP1     = 4'd6;
  localparam logic [STEP_W-1:0] STEP_MULCB2  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_LP2     = 4'd8;
  localparam logic [STEP_W-1:0] STEP_DIFF2   = 4'd9;
  localparam logic [STEP_W-1:0] STEP_MULCD2  = 4'd10;
  localparam logic [STEP_W-1:0] STEP_BP2     = 4'd11;
  localparam logic [STEP_W-1:0] STEP_LAST    = STEP_BP2;

  typedef enum logic [1:0] {
    MUL_NONE = 2'd0,
    MUL_CB   = 2'd1,
    MUL_BD   = 2'd2,
    MUL_CD   = 2'd3
  } mul_sel_t;

  typedef enum logic [1:0] {
    JMP_NEXT = 2'd0,
    JMP_LOOP = 2'd1,
    JMP_HOME = 2'd2
  } jump_t;

  typedef struct packed {
    logic     wait_in;
    logic     wait_out;
    logic     capture;
    logic     tick;
    logic     acc_clr;
    logic     acc_add;
    logic     osc_upd;
    mul_sel_t mul_sel;
    logic     lp_upd;
    logic     diff_upd;
    logic     bp_upd;
    logic     emit;
    jump_t    jump;
  } ucode_t;

  localparam ucode_t UCODE_NOP = '{
    wait_in:  1'b0,
    wait_out: 1'b0,
    capture:  1'b0,
    tick:     1'b0,
    acc_clr:  1'b0,
    acc_add:  1'b0,
    osc_upd:  1'b0,
    mul_sel:  MUL_NONE,
    lp_upd:   1'b0,
    diff_upd: 1'b0,
    bp_upd:   1'b0,
    emit:     1'b0,
    jump:     JMP_NEXT
  };

  // control store
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = UCODE_NOP;
    unique case (step)
      STEP_IDLE: begin
        w.wait_in = 1'b1;
        w.capture = 1'b1;
        w.acc_clr = 1'b1;
      end
      STEP_TICK: begin
        w.tick    = 1'b1;
        w.acc_add = 1'b1;
        w.jump    = JMP_LOOP;
      end
      STEP_DRAIN: begin
        w.acc_add = 1'b1;
        w.mul_sel = MUL_CB;
      end
      STEP_OSC: begin
        w.osc_upd = 1'b1;
        w.mul_sel = MUL_BD;
        w.lp_upd  = 1'b1;
      end
      STEP_DIFF1:  w.diff_upd = 1'b1;
      STEP_MULCD1: w.mul_sel  = MUL_CD;
      STEP_BP1:    w.bp_upd   = 1'b1;
      STEP_MULCB2: w.mul_sel  = MUL_CB;
      STEP_LP2: begin
        w.mul_sel = MUL_BD;
        w.lp_upd  = 1'b1;
      end
      STEP_DIFF2:  w.diff_upd = 1'b1;
      STEP_MULCD2: w.mul_sel  = MUL_CD;
      STEP_BP2: begin
        w.wait_out = 1'b1;
        w.bp_upd   = 1'b1;
        w.emit     = 1'b1;
        w.jump     = JMP_HOME;
      end
      default: w.jump = JMP_HOME;
    endcase
    return w;
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [EXT_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[EXT_W-1:DATA_W-1] == '0 || v[EXT_W-1:DATA_W-1] == '1) begin
      r = v[DATA_W-1:0];
    end else if (v[EXT_W-1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

/* sv/dosv_osc_bank.sv */
// oscillator lanes, oversampled masked-phase accumulator and conversion to q2.24
module dosv_osc_bank (
  input  logic                                    clk,
  input  logic                                    rst,
  input  dosv_pkg::ucode_t                        ctl,
  input  logic [dosv_pkg::PHASE_W-1:0]            base_increment,
  input  logic [dosv_pkg::PHASE_W-1:0]            detune_step,
  input  logic [dosv_pkg::MASK_W-1:0]             wave_mask_top,
  output logic signed [dosv_pkg::OSC_W-1:0]       osc
);

  logic [dosv_pkg::PHASE_W-1:0] inc   [dosv_pkg::NUM_OSC];
  logic [dosv_pkg::PHASE_W-1:0] phase [dosv_pkg::NUM_OSC];
  logic [dosv_pkg::PHASE_W-1:0] mask;
  logic [dosv_pkg::PSUM_W-1:0]  psum_next;
  logic [dosv_pkg::PSUM_W-1:0]  psum;
  logic [dosv_pkg::SUM_W-1:0]   acc;
  logic [dosv_pkg::SUM_W:0]     twice;
  logic [dosv_pkg::SUM_W:0]     y_full;
  logic [dosv_pkg::Y_W-1:0]     y;
  logic [dosv_pkg::OSCM_W-1:0]  oscm;
  logic                         neg;

  assign mask = {wave_mask_top, {(dosv_pkg::PHASE_W-dosv_pkg::MASK_W){1'b0}}};

  // one lane per oscillator, increments follow the config registers
  for (genvar i = 0; i < dosv_pkg::NUM_OSC; i++) begin : g_lane
    always_ff @(posedge clk) begin
      inc[i] <= base_increment + detune_step * dosv_pkg::PHASE_W'(i);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        phase[i] <= '0;
      end else if (ctl.tick) begin
        phase[i] <= phase[i] + inc[i];
      end
    end
  end

  always_comb begin
    psum_next = '0;
    for (int i = 0; i < dosv_pkg::NUM_OSC; i++) begin
      psum_next = psum_next + dosv_pkg::PSUM_W'(phase[i] & mask);
    end
  end

  // lane sum is registered, accumulator trails by one tick
  always_ff @(posedge clk) begin
    if (ctl.acc_clr) begin
      psum <= '0;
      acc  <= '0;
    end else begin
      if (ctl.tick) begin
        psum <= psum_next;
      end
      if (ctl.acc_add) begin
        acc <= acc + dosv_pkg::SUM_W'(psum);
      end
    end
  end

  // floor((2*sum - n) / (n * 1024))
  assign twice  = {acc, 1'b0};
  assign y_full = twice - (dosv_pkg::SUM_W + 1)'(dosv_pkg::NUM_OSC);
  assign y      = y_full[dosv_pkg::SUM_W:10];

  always_ff @(posedge clk) begin
    if (ctl.osc_upd) begin
      oscm <= y * dosv_pkg::RECIP_M;
      neg  <= (twice < (dosv_pkg::SUM_W + 1)'(dosv_pkg::NUM_OSC));
    end
  end

  assign osc = neg ? '1 : {1'b0, oscm[dosv_pkg::RECIP_K +: dosv_pkg::OSC_W-1]};

endmodule

/* sv/dosv_svf.sv */
// two-pass state-variable filter datapath around one shared multiplier
module dosv_svf (
  input  logic                                  clk,
  input  logic                                  rst,
  input  dosv_pkg::ucode_t                      ctl,
  input  logic [dosv_pkg::CUT_W-1:0]            cutoff_coef,
  input  logic [dosv_pkg::DAMP_W-1:0]           damping_coef,
  input  logic signed [dosv_pkg::OSC_W-1:0]     osc,
  output logic signed [dosv_pkg::DATA_W-1:0]    lp
);

  logic [dosv_pkg::CUT_W-1:0]          c_reg;
  logic [dosv_pkg::DAMP_W-1:0]         d_reg;
  logic signed [dosv_pkg::DATA_W-1:0]  bp;
  logic signed [dosv_pkg::DIFF_W-1:0]  diff;
  logic signed [dosv_pkg::MUL_A_W-1:0] mul_a;
  logic signed [dosv_pkg::MUL_B_W-1:0] mul_b;
  logic signed [dosv_pkg::PROD_W-1:0]  prod;
  logic signed [dosv_pkg::SH_W-1:0]    prod_sh;
  logic signed [dosv_pkg::EXT_W-1:0]   lp_sum;
  logic signed [dosv_pkg::EXT_W-1:0]   bp_sum;
  logic signed [dosv_pkg::EXT_W-1:0]   diff_sum;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      c_reg <= cutoff_coef;
      d_reg <= damping_coef;
    end
  end

  always_comb begin
    unique case (ctl.mul_sel)
      dosv_pkg::MUL_CB: begin
        mul_a = dosv_pkg::MUL_A_W'(bp);
        mul_b = {2'b00, c_reg};
      end
      dosv_pkg::MUL_BD: begin
        mul_a = dosv_pkg::MUL_A_W'(bp);
        mul_b = {1'b0, d_reg};
      end
      dosv_pkg::MUL_CD: begin
        mul_a = diff;
        mul_b = {2'b00, c_reg};
      end
      dosv_pkg::MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_sel != dosv_pkg::MUL_NONE) begin
      prod <= mul_a * mul_b;
    end
  end

  // floor shift of the last product
  assign prod_sh  = signed'(prod[dosv_pkg::PROD_W-1:dosv_pkg::FRAC_W]);
  assign lp_sum   = dosv_pkg::EXT_W'(lp) + dosv_pkg::EXT_W'(prod_sh);
  assign bp_sum   = dosv_pkg::EXT_W'(bp) + dosv_pkg::EXT_W'(prod_sh);
  assign diff_sum = dosv_pkg::EXT_W'(osc) - dosv_pkg::EXT_W'(lp) - dosv_pkg::EXT_W'(prod_sh);

  always_ff @(posedge clk) begin
    if (ctl.diff_upd) begin
      diff <= diff_sum[dosv_pkg::DIFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lp <= '0;
      bp <= '0;
    end else begin
      if (ctl.lp_upd) begin
        lp <= dosv_pkg::sat32(lp_sum);
      end
      if (ctl.bp_upd) begin
        bp <= dosv_pkg::sat32(bp_sum);
      end
    end
  end

endmodule

/* sv/detuned_osc_bank_svf_voice_unit.sv */
// top level of the detuned oscillator bank voice with state-variable filter
//
// in channel: in_valid/in_ready carry one word per output sample, holding
// cutoff_coef (q0.16) and damping_coef (q1.16, 65536 is one). out channel:
// out_valid/out_ready carry one lowpass_sample word (q7.24, saturated) per
// input word, in order.
// config: cfg_we writes cfg_data into register cfg_index (0 base increment,
// 1 detune step, 2 top byte of the phase mask) at the clock edge; other
// indexes are dropped. write only while the block is idle.
// sequencing: a microcoded sequencer walks a 12-step control store. one idle
// step takes the word, one tick step repeats OVERSAMPLE times (all lanes
// advance together), then ten steps run the oscillator sum conversion and
// the two filter passes through one shared 34x18 multiplier.
// a word is taken only in the idle step, so the next word waits until the
// current one has run every step; in_ready returns once the result is
// registered.
// stall: the result sits in the output register; the next word is taken and
// worked on meanwhile, and the last step waits only if the register is full.
// reset (synchronous, rst high): phases, filter state and the output valid
// flag clear, registers go to 0, 0 and 255.
module detuned_osc_bank_svf_voice_unit (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [dosv_pkg::CUT_W-1:0]               cutoff_coef,
  input  logic [dosv_pkg::DAMP_W-1:0]              damping_coef,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [dosv_pkg::DATA_W-1:0]       lowpass_sample,
  input  logic                                     cfg_we,
  input  logic [dosv_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [dosv_pkg::PHASE_W-1:0]             cfg_data
);

  // config registers
  logic [dosv_pkg::PHASE_W-1:0] base_increment;
  logic [dosv_pkg::PHASE_W-1:0] detune_step;
  logic [dosv_pkg::MASK_W-1:0]  wave_mask_top;

  // sequencer
  logic [dosv_pkg::STEP_W-1:0] upc;
  logic [dosv_pkg::STEP_W-1:0] upc_next;
  logic [dosv_pkg::REP_W-1:0]  rep;
  logic [dosv_pkg::REP_W-1:0]  rep_next;
  dosv_pkg::ucode_t            cw;
  dosv_pkg::ucode_t            ctl;
  logic                        hold;
  logic                        rep_done;

  // datapath links
  logic signed [dosv_pkg::OSC_W-1:0]  osc;
  logic signed [dosv_pkg::DATA_W-1:0] lp;
  logic                               out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_increment <= '0;
      detune_step    <= '0;
      wave_mask_top  <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dosv_pkg::REG_BASE_INCREMENT: base_increment <= cfg_data;
        dosv_pkg::REG_DETUNE_STEP:    detune_step    <= cfg_data;
        dosv_pkg::REG_WAVE_MASK_TOP:  wave_mask_top  <= cfg_data[dosv_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // fetch the control word; a waiting step does nothing
  assign cw       = dosv_pkg::ucode_rom(upc);
  assign hold     = (cw.wait_in && !in_valid) || (cw.wait_out && out_valid && !out_ready);
  assign ctl      = hold ? dosv_pkg::UCODE_NOP : cw;
  assign in_ready = (upc == dosv_pkg::STEP_IDLE) && !rst;
  assign rep_done = (rep == dosv_pkg::REP_W'(dosv_pkg::OVERSAMPLE - 1));

  always_comb begin
    upc_next = upc;
    rep_next = rep;
    if (!hold) begin
      unique case (cw.jump)
        dosv_pkg::JMP_NEXT: upc_next = upc + 1'b1;
        dosv_pkg::JMP_LOOP: begin
          if (rep_done) begin
            upc_next = upc + 1'b1;
            rep_next = '0;
          end else begin
            rep_next = rep + 1'b1;
          end
        end
        dosv_pkg::JMP_HOME: upc_next = dosv_pkg::STEP_IDLE;
        default:            upc_next = dosv_pkg::STEP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= dosv_pkg::STEP_IDLE;
      rep <= '0;
    end else begin
      upc <= upc_next;
      rep <= rep_next;
    end
  end

  dosv_osc_bank u_osc_bank (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .base_increment (base_increment),
    .detune_step    (detune_step),
    .wave_mask_top  (wave_mask_top),
    .osc            (osc)
  );

  dosv_svf u_svf (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .cutoff_coef  (cutoff_coef),
    .damping_coef (damping_coef),
    .osc          (osc),
    .lp           (lp)
  );

  // output register
  always_comb begin
    out_valid_next = out_valid;
    if (ctl.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      lowpass_sample <= lp;
    end
  end

  // the program counter stays inside the control store
  a_upc_range: assert property (@(posedge clk) disable iff (rst)
    upc <= dosv_pkg::STEP_LAST)
    else $error("sequencer left the control store");

  // a taken word starts the oscillator ticks next cycle
  a_accept_tick: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (upc == dosv_pkg::STEP_TICK))
    else $error("accepted word did not start the tick loop");

  // the repeat counter only runs inside the tick loop
  a_rep_idle: assert property (@(posedge clk) disable iff (rst)
    (upc != dosv_pkg::STEP_TICK) |-> (rep == '0))
    else $error("repeat counter nonzero outside the tick loop");

  // a result is never written over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> !(out_valid && !out_ready))
    else $error("output word overwritten while stalled");

endmodule

/* sim/voice_sample_checker.sv */
// watches both channels and the register port, predicts each voice sample and checks it
module voice_sample_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [dosv_pkg::CUT_W-1:0]          cutoff_coef,
  input  logic [dosv_pkg::DAMP_W-1:0]         damping_coef,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [dosv_pkg::DATA_W-1:0]  lowpass_sample,
  input  logic                                cfg_we,
  input  logic [dosv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dosv_pkg::PHASE_W-1:0]        cfg_data,
  output int                                  fail_count,
  output int                                  pending
);
  import dosv_pkg::*;

  logic [PHASE_W-1:0]       phase_acc [NUM_OSC];
  logic signed [DATA_W-1:0] lp_st;
  logic signed [DATA_W-1:0] bp_st;
  logic [PHASE_W-1:0]       base_inc;
  logic [PHASE_W-1:0]       detune;
  logic [MASK_W-1:0]        mask_top;
  logic signed [DATA_W-1:0] expected_samples [$];
  int                       mismatches = 0;

  function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < -64'sd2147483648) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

  // one chamberlin pass, floor shifts on exact 64-bit products
  function automatic void svf_pass(input longint osc, input longint c, input longint d);
    longint diff;
    lp_st = clamp32(longint'(lp_st) + ((c * longint'(bp_st)) >>> FRAC_W));
    diff  = osc - longint'(lp_st) - ((longint'(bp_st) * d) >>> FRAC_W);
    bp_st = clamp32(longint'(bp_st) + ((c * diff) >>> FRAC_W));
  endfunction

  // steps the bank, converts the phase sum and runs both filter passes
  function automatic logic signed [DATA_W-1:0] next_sample(input logic [CUT_W-1:0] cut,
                                                          input logic [DAMP_W-1:0] damp);
    longint unsigned phase_sum;
    longint          osc_val;
    logic [PHASE_W-1:0] p;
    logic [PHASE_W-1:0] stp;
    logic [PHASE_W-1:0] mask32;
    phase_sum = 0;
    mask32    = {mask_top, 24'h0};
    stp       = base_inc;
    for (int i = 0; i < NUM_OSC; i++) begin
      p = phase_acc[i];
      for (int k = 0; k < OVERSAMPLE; k++) begin
        phase_sum += 64'(p & mask32);
        p = p + stp;
      end
      phase_acc[i] = p;
      stp = stp + detune;
    end
    // divide by a power of two, so an arithmetic shift gives the floor
    osc_val = (2 * longint'(phase_sum) - longint'(NUM_OSC)) >>> $clog2(NUM_OSC * 1024);
    svf_pass(osc_val, longint'(cut), longint'(damp));
    svf_pass(osc_val, longint'(cut), longint'(damp));
    return lp_st;
  endfunction

  always @(posedge clk) begin : watch
    logic signed [DATA_W-1:0] exp_smp;
    if (rst) begin
      for (int i = 0; i < NUM_OSC; i++) phase_acc[i] = '0;
      lp_st    = '0;
      bp_st    = '0;
      base_inc = '0;
      detune   = '0;
      mask_top = 8'hFF;
      expected_samples.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $error("lowpass_sample: no word expected, actual %0d", lowpass_sample);
          mismatches++;
        end else begin
          exp_smp = expected_samples.pop_front();
          if (exp_smp !== lowpass_sample) begin
            $error("lowpass_sample: expected %0d, actual %0d", exp_smp, lowpass_sample);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_BASE_INCREMENT: base_inc = cfg_data;
          REG_DETUNE_STEP:    detune   = cfg_data;
          REG_WAVE_MASK_TOP:  mask_top = cfg_data[MASK_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_samples.push_back(next_sample(cutoff_coef, damping_coef));
      end
    end
    fail_count <= mismatches;
    pending    <= expected_samples.size();
  end

endmodule

/* sim/tb_top.sv */
// stimulus, clock, reset and verdict for the detuned oscillator bank voice
module tb_top;
  import dosv_pkg::*;

  localparam int RESET_CYCLES  = 8;
  // a little over one item time, so the sequencer is surely home
  localparam int SETTLE_CYCLES = 24;
  // long output stall, well past one item time so the input backs up
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_WORDS   = 50;
  // slowest run is roughly 450 words, each with its item time and random gaps on both sides, plus pauses
  localparam int CYCLE_LIMIT   = 400000;
  // index 3 maps to no register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                     clk          = 1'b0;
  logic                     rst          = 1'b1;
  logic                     in_valid     = 1'b0;
  logic                     in_ready;
  logic [CUT_W-1:0]         cutoff_coef  = '0;
  logic [DAMP_W-1:0]        damping_coef = '0;
  logic                     out_valid;
  logic                     out_ready    = 1'b0;
  logic signed [DATA_W-1:0] lowpass_sample;
  logic                     cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index    = REG_BASE_INCREMENT;
  logic [PHASE_W-1:0]       cfg_data     = '0;

  int fail_count;
  int pending;
  int cycle_count = 0;
  // calm: no gaps on either side for the current phase
  bit calm        = 1'b0;
  // hold_req: asks the receiver for one long stall
  bit hold_req    = 1'b0;

  always #1 clk = ~clk;

  detuned_osc_bank_svf_voice_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cutoff_coef    (cutoff_coef),
    .damping_coef   (damping_coef),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .lowpass_sample (lowpass_sample),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  voice_sample_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cutoff_coef    (cutoff_coef),
    .damping_coef   (damping_coef),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .lowpass_sample (lowpass_sample),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("detuned_osc_bank_svf_voice_unit verification failed");
      $finish;
    end
  end

  // receiver: random stall before each word, or one long hold on request
  initial begin : rx
    int stall;
    bit held;
    held = 1'b0;
    forever begin
      if (hold_req && !held) begin
        stall = HOLD_CYCLES;
        held  = 1'b1;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 5);
      end
      // lower ready only when there is a stall, so ready never drops and rises in one step
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // offer one word, hold it until taken, then draw the gap before the next
  task automatic send_word(input logic [CUT_W-1:0] c, input logic [DAMP_W-1:0] d);
    int gap;
    in_valid     <= 1'b1;
    cutoff_coef  <= c;
    damping_coef <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering, wait out every expected word, then let the sequencer go home
  task automatic drain();
    in_valid <= 1'b0;
    // one edge first so the count includes the word taken at the last edge
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write enable stays high across back-to-back writes, lowered by the caller
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PHASE_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic program_voice(input logic [PHASE_W-1:0] base, input logic [PHASE_W-1:0] det,
                               input logic [PHASE_W-1:0] mask_data, input bit poke_spare);
    write_reg(REG_BASE_INCREMENT, base);
    write_reg(REG_DETUNE_STEP, det);
    write_reg(REG_WAVE_MASK_TOP, mask_data);
    if (poke_spare) write_reg(REG_SPARE, $urandom);
    cfg_we <= 1'b0;
  endtask

  initial begin : stim
    logic [CUT_W-1:0]   c;
    logic [DAMP_W-1:0]  d;
    logic [PHASE_W-1:0] base;
    logic [PHASE_W-1:0] det;
    logic [PHASE_W-1:0] mask_data;
    int                 pick;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset registers: the bank stays at zero, so the converter floors to -1
    calm = 1'b1;
    send_word(16'h0000, 17'd0);
    send_word(16'hFFFF, 17'd65536);
    send_word(16'hFFFF, 17'd131071);   // damping above one
    send_word(16'hFFFF, 17'd0);
    send_word(16'h0001, 17'd1);
    send_word(16'h8000, 17'd32768);
    drain();

    // sawtooth with a moderate spread
    program_voice(32'h0100_0000, 32'h0012_3456, 32'h0000_00FF, 1'b0);
    calm = 1'b0;
    send_word(16'hFFFF, 17'd0);        // no damping, drives the state toward saturation
    send_word(16'h4000, 17'd8192);
    send_word(16'h0000, 17'd65536);
    send_word(16'hFFFF, 17'd131071);
    send_word(16'h1234, 17'h1ABCD);
    send_word(16'hFFFF, 17'd0);
    drain();

    // pulse mask, widest steps so every lane wraps
    program_voice(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0080, 1'b0);
    send_word(16'hFFFF, 17'd65536);
    send_word(16'h7FFF, 17'd0);
    send_word(16'h0000, 17'd131071);
    send_word(16'hA5A5, 17'h0A5A5);
    send_word(16'h5A5A, 17'h15A5A);
    drain();

    // mask below 128 written with junk in the upper bits, plus a write to the spare index
    program_voice(32'h8000_0000, 32'h0000_0000, 32'hFFFF_FF7F, 1'b1);
    send_word(16'hFFFF, 17'd0);
    send_word(16'hC000, 17'd4096);
    send_word(16'h0100, 17'd65535);
    send_word(16'hFFFF, 17'd131071);
    send_word(16'h0000, 17'd0);
    drain();

    // random phases, each with its own register setting and idling mode
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      pick = $urandom_range(0, 3);
      base = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
      pick = $urandom_range(0, 4);
      det  = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF :
             (pick == 2) ? 32'($urandom_range(0, 32'h0010_0000)) : $urandom;
      pick = $urandom_range(0, 5);
      mask_data = (pick == 0) ? 32'h0000_0080 : (pick == 1) ? 32'h0000_00FF :
                  (pick == 2) ? 32'($urandom_range(0, 255)) :
                  32'($urandom_range(128, 255));
      // upper bits of the data are dropped by the narrow register
      mask_data = ($urandom & 32'hFFFF_FF00) | mask_data;
      program_voice(base, det, mask_data, $urandom_range(0, 3) == 0);

      calm = (ph % 3 == 1);
      // one long receiver hold while the sender keeps offering words
      if (ph == 2) hold_req = 1'b1;

      for (int n = 0; n < PHASE_WORDS; n++) begin
        pick = $urandom_range(0, 7);
        c = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 9);
        d = (pick == 0) ? 17'd0 : (pick == 1) ? 17'd65536 : (pick == 2) ? 17'd131071 :
            (pick < 5) ? 17'($urandom_range(65537, 131071)) : 17'($urandom_range(0, 65536));
        send_word(c, d);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("detuned_osc_bank_svf_voice_unit verification clean");
    end else begin
      $display("detuned_osc_bank_svf_voice_unit verification failed");
    end
    $finish;
  end

endmodule
